// ===== rtl/mask_filtered_sorted_id_set_top_assert.svh =====
// Assertion macros for the sorted id set
`ifndef MASK_FILTERED_SORTED_ID_SET_TOP_ASSERT_SVH
`define MASK_FILTERED_SORTED_ID_SET_TOP_ASSERT_SVH

`ifndef SYNTH

`define MFSIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

`define MFSIS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`else

`define MFSIS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define MFSIS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mfsis_pkg.sv =====
`default_nettype none
package mfsis_pkg;

	localparam int MAX_ENTITIES_DEF   = 256;
	localparam int COMPONENT_BITS_DEF = 32;

	localparam int ENT_W   = 8;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 9;
	localparam int CMD_W   = 2;

	localparam logic [CMD_W-1:0] CMD_ACTIVATE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEACTIVATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ       = 2'd2;

	localparam logic REG_REQ_COMPONENTS = 1'b0;
	localparam logic REG_REQ_EVENTS     = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ENT_W-1:0]  entity_index;
		logic [DATA_W-1:0] component_bits;
		logic              has_event_component;
		logic [DATA_W-1:0] event_bits;
		logic [ENT_W-1:0]  read_position;
	} mfsis_in_t;

	typedef struct packed {
		logic               is_member;
		logic               changed;
		logic [COUNT_W-1:0] member_count;
		logic [ENT_W-1:0]   read_entity;
		logic               read_valid;
	} mfsis_out_t;

	// broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [ENT_W-1:0] idx;
	} mfsis_op_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic [ENT_W-1:0] val;
		logic             vld;
		logic             lt;
	} mfsis_link_t;

	function automatic logic [DATA_W-1:0] comp_mask(input int bits);
		logic [DATA_W-1:0] m;
		for (int i = 0; i < DATA_W; i++) begin
			m[i] = (i < bits);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mfsis_cell.sv =====
`default_nettype none
module mfsis_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  mfsis_pkg::mfsis_op_t   op,
	input  mfsis_pkg::mfsis_link_t left,
	input  mfsis_pkg::mfsis_link_t right,
	output mfsis_pkg::mfsis_link_t self
);
	import mfsis_pkg::*;

	logic [ENT_W-1:0] val_q;
	logic             vld_q;
	logic             lt;

	assign lt = vld_q && (val_q < op.idx);

	assign self.val = val_q;
	assign self.vld = vld_q;
	assign self.lt  = lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (op.ins && !lt) begin
			vld_q <= left.lt ? 1'b1 : left.vld;
		end else if (op.rem && vld_q && !lt) begin
			vld_q <= right.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (op.ins && !lt) begin
			val_q <= left.lt ? op.idx : left.val;
		end else if (op.rem && vld_q && !lt) begin
			val_q <= right.val;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mfsis_chain.sv =====
`default_nettype none
module mfsis_chain #(
	parameter int DEPTH = 256,
	parameter int IW    = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  mfsis_pkg::mfsis_op_t        op,
	input  wire  [IW-1:0]               rd_addr,
	output logic [mfsis_pkg::ENT_W-1:0] rd_entity
);
	import mfsis_pkg::*;

	mfsis_link_t lnk [DEPTH+1];
	logic [ENT_W-1:0] val_w [DEPTH];

	// head of the chain: always "below" so cell 0 takes the new entry unless its own entry is lower
	assign lnk[0] = '{val: '0, vld: 1'b0, lt: 1'b1};

	localparam mfsis_link_t TAIL = '{val: '0, vld: 1'b0, lt: 1'b0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		mfsis_link_t right_w;
		if (i == DEPTH - 1) begin : g_tail
			assign right_w = TAIL;
		end else begin : g_mid
			assign right_w = lnk[i+2];
		end
		mfsis_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.left   (lnk[i]),
			.right  (right_w),
			.self   (lnk[i+1])
		);
		assign val_w[i] = lnk[i+1].val;
	end

	assign rd_entity = val_w[rd_addr];

endmodule
`default_nettype wire

// ===== rtl/mask_filtered_sorted_id_set_top.sv =====
// The result is registered in the cycle after the command transaction is accepted.
// Throughput: 1 transaction per cycle while not stalled; insert/remove shifts the whole cell chain at once.
// The command side stalls only while a finished result waits on a stalled result side.
// Reset: clears membership bitmap, member count, cell valid bits and filter registers.
`default_nettype none
module mask_filtered_sorted_id_set_top #(
	parameter int MAX_ENTITIES   = mfsis_pkg::MAX_ENTITIES_DEF,
	parameter int COMPONENT_BITS = mfsis_pkg::COMPONENT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cmd_valid,
	output logic                         cmd_stall,
	input  mfsis_pkg::mfsis_in_t         cmd_data,
	output logic                         res_valid,
	input  wire                          res_stall,
	output mfsis_pkg::mfsis_out_t        res_data,
	input  wire                          cfg_we,
	input  wire                          cfg_idx,
	input  wire  [mfsis_pkg::DATA_W-1:0] cfg_wdata
);
	import mfsis_pkg::*;

	localparam int DEPTH = (MAX_ENTITIES < 256) ? MAX_ENTITIES : 256;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [DATA_W-1:0] CMASK = comp_mask(COMPONENT_BITS);

	logic [DATA_W-1:0]  req_comp_q;
	logic [DATA_W-1:0]  req_evt_q;
	logic [DEPTH-1:0]   bitmap_q;
	logic [COUNT_W-1:0] count_q;
	logic               res_valid_q;
	mfsis_out_t         res_q;

	logic               accept;
	logic               in_range;
	logic [IW-1:0]      bidx;
	logic               member;
	logic               keep;
	logic               passes;
	logic [DATA_W-1:0]  req_m;
	logic               rvalid;
	logic [ENT_W-1:0]   rd_entity;
	logic [COUNT_W-1:0] count_next;
	mfsis_op_t          op;
	mfsis_out_t         res_d;

	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_comp_q <= '0;
			req_evt_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REQ_COMPONENTS: req_comp_q <= cfg_wdata;
				REG_REQ_EVENTS:     req_evt_q  <= cfg_wdata;
				default:            req_comp_q <= req_comp_q;
			endcase
		end
	end

	assign in_range = (int'(cmd_data.entity_index) < MAX_ENTITIES);
	assign bidx     = cmd_data.entity_index[IW-1:0];
	assign member   = in_range && bitmap_q[bidx];
	assign req_m    = req_comp_q & CMASK;
	assign passes   = (((cmd_data.component_bits & CMASK) & req_m) == req_m)
		&& (!cmd_data.has_event_component
			|| ((cmd_data.event_bits & req_evt_q) == req_evt_q));
	assign keep     = (cmd_data.command == CMD_ACTIVATE) && passes;

	always_comb begin
		op.idx = cmd_data.entity_index;
		op.ins = 1'b0;
		op.rem = 1'b0;
		if (accept && in_range && (cmd_data.command == CMD_ACTIVATE
				|| cmd_data.command == CMD_DEACTIVATE)) begin
			op.ins = keep && !member;
			op.rem = !keep && member;
		end
	end

	assign count_next = op.ins ? count_q + 9'd1 : (op.rem ? count_q - 9'd1 : count_q);
	assign rvalid     = ({1'b0, cmd_data.read_position} < count_q);

	always_comb begin
		res_d              = '0;
		res_d.member_count = count_next;
		case (cmd_data.command)
			CMD_ACTIVATE, CMD_DEACTIVATE: begin
				res_d.is_member = in_range && keep;
				res_d.changed   = op.ins || op.rem;
			end
			CMD_READ: begin
				res_d.read_valid  = rvalid;
				res_d.is_member   = rvalid;
				res_d.read_entity = rvalid ? rd_entity : '0;
			end
			default: res_d.is_member = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q <= '0;
			count_q  <= '0;
		end else begin
			if (op.ins) begin
				bitmap_q[bidx] <= 1'b1;
			end else if (op.rem) begin
				bitmap_q[bidx] <= 1'b0;
			end
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	mfsis_chain #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.rd_addr   (cmd_data.read_position[IW-1:0]),
		.rd_entity (rd_entity)
	);

`include "mask_filtered_sorted_id_set_top_assert.svh"

	`MFSIS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= COUNT_W'(DEPTH))
	`MFSIS_ASSERT_NXT(a_ins_count, clk, arst_n, op.ins, count_q == $past(count_q) + 9'd1)
	`MFSIS_ASSERT_NXT(a_rem_count, clk, arst_n, op.rem, count_q == $past(count_q) - 9'd1)
	`MFSIS_ASSERT_IMP(a_rem_needs_entry, clk, arst_n, op.rem, count_q != 9'd0)

endmodule
`default_nettype wire

// ===== test/sorted_set_checker.sv =====
module sorted_set_checker (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	input  wire                   cmd_stall,
	input  mfsis_pkg::mfsis_in_t  cmd_data,
	input  wire                   res_valid,
	input  wire                   res_stall,
	input  mfsis_pkg::mfsis_out_t res_data,
	input  wire                   cfg_we,
	input  wire                   cfg_idx,
	input  wire  [31:0]           cfg_wdata,
	output int                    fails,
	output int                    backlog
);
	import mfsis_pkg::*;

	logic [DATA_W-1:0] need_comp;
	logic [DATA_W-1:0] need_evt;
	logic [255:0]      in_set;
	logic [ENT_W-1:0]  roster [256];
	int                roster_len;
	mfsis_out_t        due_q [$];

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		fails++;
	endtask

	// advances the set by one command transaction and returns the reply it owes
	task automatic apply_event(input mfsis_in_t ev, output mfsis_out_t r);
		int pos;
		int i;
		logic keep;
		logic [ENT_W-1:0] idx;
		r = '0;
		idx = ev.entity_index;
		case (ev.command)
			CMD_ACTIVATE, CMD_DEACTIVATE: begin
				keep = (ev.command == CMD_ACTIVATE)
					&& ((ev.component_bits & need_comp) == need_comp)
					&& (!ev.has_event_component
						|| ((ev.event_bits & need_evt) == need_evt));
				if (keep && !in_set[idx]) begin
					if (roster_len < 256) begin
						pos = 0;
						while (pos < roster_len && roster[pos] < idx) pos++;
						for (i = roster_len; i > pos; i--) roster[i] = roster[i-1];
						roster[pos] = idx;
						roster_len++;
					end
					in_set[idx] = 1'b1;
					r.changed = 1'b1;
				end else if (!keep && in_set[idx]) begin
					pos = 0;
					while (pos < roster_len && roster[pos] != idx) pos++;
					if (pos < roster_len) begin
						for (i = pos; i + 1 < roster_len; i++) roster[i] = roster[i+1];
						roster_len--;
					end
					in_set[idx] = 1'b0;
					r.changed = 1'b1;
				end
				r.is_member = in_set[idx];
			end
			CMD_READ: begin
				if (ev.read_position < roster_len) begin
					r.read_entity = roster[ev.read_position];
					r.read_valid = 1'b1;
					r.is_member = 1'b1;
				end
			end
			default: ;
		endcase
		r.member_count = roster_len[COUNT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		mfsis_out_t want;
		if (!arst_n) begin
			need_comp = '0;
			need_evt = '0;
			in_set = '0;
			roster_len = 0;
			due_q.delete();
			fails = 0;
			backlog <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_q.size() == 0) begin
					report("result transaction with nothing pending");
				end else begin
					want = due_q.pop_front();
					if (res_data.is_member !== want.is_member)
						report($sformatf("is_member %0b, want %0b",
							res_data.is_member, want.is_member));
					if (res_data.changed !== want.changed)
						report($sformatf("changed %0b, want %0b",
							res_data.changed, want.changed));
					if (res_data.member_count !== want.member_count)
						report($sformatf("member_count %0d, want %0d",
							res_data.member_count, want.member_count));
					if (res_data.read_entity !== want.read_entity)
						report($sformatf("read_entity %0d, want %0d",
							res_data.read_entity, want.read_entity));
					if (res_data.read_valid !== want.read_valid)
						report($sformatf("read_valid %0b, want %0b",
							res_data.read_valid, want.read_valid));
				end
			end
			if (cmd_valid && !cmd_stall) begin
				apply_event(cmd_data, want);
				due_q.insert(due_q.size(), want);
			end
			if (cfg_we) begin
				if (cfg_idx == REG_REQ_COMPONENTS) need_comp = cfg_wdata;
				else need_evt = cfg_wdata;
			end
			backlog <= due_q.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
module testbench;
	import mfsis_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	mfsis_in_t         cmd_data = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	mfsis_out_t        res_data;
	logic              cfg_we = 1'b0;
	logic              cfg_idx = REG_REQ_COMPONENTS;
	logic [DATA_W-1:0] cfg_wdata = '0;
	logic              calm = 1'b0;
	logic [DATA_W-1:0] want_comp = '0;
	logic [DATA_W-1:0] want_evt = '0;
	int                fails;
	int                backlog;

	mask_filtered_sorted_id_set_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	sorted_set_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.backlog   (backlog)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2000000;
		$display("mask_filtered_sorted_id_set_top regression: fail");
		$finish;
	end

	// result side backpressure, drawn per transaction
	initial begin
		int n;
		wait (arst_n);
		forever begin
			n = calm ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid && !res_stall));
		end
	end

	function automatic mfsis_in_t cmd_item(input logic [CMD_W-1:0] cmd,
			input logic [ENT_W-1:0] idx, input logic [DATA_W-1:0] comp,
			input logic hev, input logic [DATA_W-1:0] evt,
			input logic [ENT_W-1:0] rpos);
		mfsis_in_t ev;
		ev.command = cmd;
		ev.entity_index = idx;
		ev.component_bits = comp;
		ev.has_event_component = hev;
		ev.event_bits = evt;
		ev.read_position = rpos;
		return ev;
	endfunction

	// mostly filter-passing content so the set actually fills and drains
	function automatic mfsis_in_t rand_event(input int act_pct);
		mfsis_in_t ev;
		int r;
		ev.entity_index = 8'($urandom_range(0, 255));
		ev.component_bits = ($urandom_range(0, 9) < 7) ? (want_comp | $urandom()) : $urandom();
		ev.has_event_component = 1'($urandom_range(0, 1));
		ev.event_bits = ($urandom_range(0, 9) < 7) ? (want_evt | $urandom()) : $urandom();
		ev.read_position = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		if (r < 3) ev.command = CMD_UNUSED;
		else if (r < 20) ev.command = CMD_READ;
		else if ($urandom_range(0, 99) < act_pct) ev.command = CMD_ACTIVATE;
		else ev.command = CMD_DEACTIVATE;
		return ev;
	endfunction

	task automatic send(input mfsis_in_t ev);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= ev;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic run_mix(input int n, input int act_pct);
		repeat (n) send(rand_event(act_pct));
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_filters(input logic [DATA_W-1:0] comp, input logic [DATA_W-1:0] evt);
		want_comp = comp;
		want_evt = evt;
		cfg_we <= 1'b1;
		cfg_idx <= REG_REQ_COMPONENTS;
		cfg_wdata <= comp;
		@(posedge clk);
		cfg_idx <= REG_REQ_EVENTS;
		cfg_wdata <= evt;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [ENT_W-1:0] order [256];
		logic [ENT_W-1:0] t;
		int j;
		int k;
		wait (arst_n);
		@(posedge clk);

		// empty filters: anything passes
		send(cmd_item(CMD_ACTIVATE, 8'd255, '0, 1'b0, '0, 8'd0));
		send(cmd_item(CMD_ACTIVATE, 8'd0, '1, 1'b1, '1, 8'd255));
		send(cmd_item(CMD_ACTIVATE, 8'd128, 32'h5555_aaaa, 1'b1, 32'haaaa_5555, 8'd0));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd0));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd1));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd2));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd3));
		send(cmd_item(CMD_READ, 8'hff, '1, 1'b1, '1, 8'd255));
		send(cmd_item(CMD_ACTIVATE, 8'd128, '1, 1'b0, '0, 8'd0));
		send(cmd_item(CMD_DEACTIVATE, 8'd128, '1, 1'b1, '1, 8'd0));
		send(cmd_item(CMD_DEACTIVATE, 8'd128, '0, 1'b0, '0, 8'd0));
		send(cmd_item(CMD_UNUSED, 8'hff, '1, 1'b1, '1, 8'hff));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd1));

		// full filters: one missing bit fails
		settle();
		set_filters('1, '1);
		send(cmd_item(CMD_ACTIVATE, 8'd5, '1, 1'b0, '0, 8'd0));
		send(cmd_item(CMD_ACTIVATE, 8'd0, 32'hffff_fffe, 1'b1, '1, 8'd0));
		send(cmd_item(CMD_ACTIVATE, 8'd7, '1, 1'b1, 32'h7fff_ffff, 8'd0));
		send(cmd_item(CMD_ACTIVATE, 8'd7, '1, 1'b1, '1, 8'd0));
		send(cmd_item(CMD_DEACTIVATE, 8'd255, '0, 1'b0, '0, 8'd0));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd0));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd1));
		send(cmd_item(CMD_READ, 8'd0, '0, 1'b0, '0, 8'd2));

		// fill every index in shuffled order, then read across the full list
		settle();
		set_filters('0, '0);
		for (k = 0; k < 256; k++) order[k] = 8'(k);
		for (k = 255; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		for (k = 0; k < 256; k++)
			send(cmd_item(CMD_ACTIVATE, order[k], $urandom(), 1'($urandom_range(0, 1)),
				$urandom(), 8'($urandom_range(0, 255))));
		for (k = 0; k < 40; k++)
			send(cmd_item(CMD_READ, 8'($urandom_range(0, 255)), $urandom(),
				1'($urandom_range(0, 1)), $urandom(),
				(k == 0) ? 8'd255 : 8'($urandom_range(0, 255))));

		settle();
		calm = 1'b1;
		set_filters($urandom() & $urandom(), $urandom() & $urandom());
		run_mix(300, 60);
		calm = 1'b0;

		settle();
		set_filters('1, '1);
		run_mix(300, 50);

		settle();
		set_filters($urandom(), $urandom());
		run_mix(250, 20);

		settle();
		set_filters('0, $urandom());
		run_mix(280, 70);

		settle();
		repeat (5) @(posedge clk);
		if (fails == 0) begin
			$display("mask_filtered_sorted_id_set_top regression: pass");
		end else begin
			$display("mask_filtered_sorted_id_set_top regression: fail");
		end
		$finish;
	end

endmodule
